### rtl/core/slphs_pkg.sv
// Shared types and constants for the sharded linear-probe hash set.
package slphs_pkg;

    localparam int FP_W    = 64;
    localparam int LIMIT_W = 7;

    localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_M1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2  = 64'h94d049bb133111eb;

    typedef enum logic [1:0] {
        RES_INSERTED = 2'd0,
        RES_PRESENT  = 2'd1,
        RES_ABSENT   = 2'd2,
        RES_FULL     = 2'd3
    } result_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Micro-op sequence for the shared multiplier.
    typedef enum logic [2:0] {
        MOP_M1  = 3'd0,
        MOP_M2  = 3'd1,
        MOP_FIN = 3'd2
    } mix_op_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mix_ctrl_t;

endpackage

### rtl/core/slphs_req_if.sv
// Request and response channel interfaces.
interface slphs_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] fp_low;
    logic [63:0] fp_high;
    modport source (output valid, req_type, fp_low, fp_high, input ready);
    modport sink   (input valid, req_type, fp_low, fp_high, output ready);
endinterface

interface slphs_rsp_if;
    logic       valid;
    logic       ready;
    logic       present;
    logic [1:0] result_code;
    modport source (output valid, present, result_code, input ready);
    modport sink   (input valid, present, result_code, output ready);
endinterface

### rtl/core/slphs_mix.sv
// Iterative splitmix64 finaliser: one 32x32 partial product per cycle.
module slphs_mix
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] din,
    output logic        done,
    output logic [63:0] dout
);
    // Each 64x64 (low half) multiply uses three partial products:
    // alo*blo, alo*bhi, ahi*blo.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PP0  = 5'b00010,
        S_PP1  = 5'b00100,
        S_PP2  = 5'b01000,
        S_OUT  = 5'b10000
    } st_t;

    st_t         st_reg, st_next;
    logic        pass_reg, pass_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [63:0] kconst;
    logic [63:0] v0;

    assign kconst = pass_reg ? slphs_pkg::MIX_M2 : slphs_pkg::MIX_M1;
    assign prod   = 64'(ma) * 64'(mb);
    assign v0     = din + slphs_pkg::MIX_ADD;

    always_comb
    begin
        ma = a_reg[31:0];
        mb = kconst[31:0];
        unique case (st_reg)
            S_PP1:   mb = kconst[63:32];
            S_PP2:
            begin
                ma = a_reg[63:32];
                mb = kconst[31:0];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st_next   = st_reg;
        pass_next = pass_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        done      = 1'b0;
        unique case (st_reg)
            S_IDLE:
                if (start)
                begin
                    a_next    = v0 ^ (v0 >> 30);
                    pass_next = 1'b0;
                    st_next   = S_PP0;
                end
            S_PP0:
            begin
                acc_next = prod;
                st_next  = S_PP1;
            end
            S_PP1:
            begin
                acc_next = acc_reg + {prod[31:0], 32'd0};
                st_next  = S_PP2;
            end
            S_PP2:
            begin
                acc_next = acc_reg + {prod[31:0], 32'd0};
                st_next  = S_OUT;
            end
            S_OUT:
                if (!pass_reg)
                begin
                    a_next    = acc_reg ^ (acc_reg >> 27);
                    pass_next = 1'b1;
                    st_next   = S_PP0;
                end
                else
                begin
                    done    = 1'b1;
                    st_next = S_IDLE;
                end
            default: st_next = S_IDLE;
        endcase
    end

    assign dout = acc_reg ^ (acc_reg >> 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            pass_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pass_reg <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end
endmodule

### rtl/core/sharded_linear_probe_hash_set_core.sv
// Top level: sharded linear-probe fingerprint set.
// Usage: requests arrive on req (req_type, fp_low, fp_high); one word per
// request leaves on rsp (present, result_code). cfg_we/cfg_wdata set the
// per-shard fill limit (reset 48); the user must write it only while
// idle, as the block itself does not enforce this.
// SHARD_COUNT and SHARD_SLOTS are powers of two.
// Sequence: hash mixing in the shared 32x32 multiplier, then for each
// probed slot a registered read, then compare and any write, then the
// response word.
// One request is in flight at a time; req.ready is high only when idle.
// Reset: valid bits and fill counters sit in memories cleared by a sweep
// of one entry per cycle over all SHARD_COUNT*SHARD_SLOTS entries (4096 by
// default). No request is taken during the sweep.
// Stall: the response is held in an output register until rsp.ready;
// the block stays busy meanwhile.
module sharded_linear_probe_hash_set_core
#(
    parameter int SHARD_COUNT = 64,
    parameter int SHARD_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    slphs_req_if.sink   req,
    slphs_rsp_if.source rsp
);
    localparam int SH_W   = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
    localparam int SL_W   = $clog2(SHARD_SLOTS);
    localparam int TOT    = SHARD_COUNT * SHARD_SLOTS;
    localparam int ADDR_W = $clog2(TOT);
    localparam int CNT_W  = SL_W + 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CMP   = 6'b010000,
        S_RESP  = 6'b100000
    } st_t;

    st_t st_reg, st_next;

    logic [6:0]        limit_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              is_query_reg;
    logic [63:0]       klo_reg, khi_reg;
    logic [SH_W-1:0]   shard_reg;
    logic [SL_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]  probes_reg, probes_next;
    logic              present_reg, present_next;
    logic [1:0]        code_reg, code_next;
    logic              wr_en;

    logic [63:0]       mem_lo [TOT];
    logic [63:0]       mem_hi [TOT];
    logic              mem_v  [TOT];
    logic [63:0]       rd_lo, rd_hi;
    logic              rd_v;
    logic [CNT_W-1:0]  fill_mem [SHARD_COUNT];
    logic [CNT_W-1:0]  fill_rd;

    logic              mix_start, mix_done;
    logic [63:0]       mix_out;
    logic [ADDR_W-1:0] addr;
    logic [SH_W-1:0]   shard_in;
    logic [CNT_W-1:0]  eff_limit;
    logic              limit_big;

    slphs_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .din   (req.fp_low),
        .done  (mix_done),
        .dout  (mix_out)
    );

    generate
        if (SHARD_COUNT > 1)
        begin : g_sh
            // Shard count is a power of two: low bits of the top field.
            assign shard_in = req.fp_low[58 +: SH_W];
            assign addr     = ADDR_W'({shard_reg, slot_reg});
        end
        else
        begin : g_sh1
            assign shard_in = 1'b0;
            assign addr     = ADDR_W'(slot_reg);
        end
    endgenerate

    assign limit_big = 32'(limit_reg) > SHARD_SLOTS;
    assign eff_limit = limit_big ? CNT_W'(SHARD_SLOTS) : CNT_W'(limit_reg);
    assign mix_start = (st_reg == S_IDLE) && req.valid;
    assign req.ready = (st_reg == S_IDLE);
    assign rsp.valid = (st_reg == S_RESP);
    assign rsp.present     = present_reg;
    assign rsp.result_code = code_reg;

    always_comb
    begin
        st_next      = st_reg;
        slot_next    = slot_reg;
        probes_next  = probes_reg;
        present_next = present_reg;
        code_next    = code_reg;
        wr_en        = 1'b0;
        unique case (st_reg)
            S_CLEAR:
                if (32'(clr_reg) == TOT - 1)
                    st_next = S_IDLE;
            S_IDLE:
                if (req.valid)
                    st_next = S_HASH;
            S_HASH:
                if (mix_done)
                begin
                    slot_next   = mix_out[SL_W-1:0];
                    probes_next = '0;
                    st_next     = S_READ;
                end
            S_READ:
                st_next = S_CMP;
            S_CMP:
            begin
                st_next = S_RESP;
                if (rd_v && rd_lo == klo_reg && rd_hi == khi_reg)
                begin
                    present_next = 1'b1;
                    code_next    = slphs_pkg::RES_PRESENT;
                end
                else if (!rd_v)
                begin
                    present_next = 1'b0;
                    if (is_query_reg)
                        code_next = slphs_pkg::RES_ABSENT;
                    else if (fill_rd >= eff_limit)
                        code_next = slphs_pkg::RES_FULL;
                    else
                    begin
                        code_next = slphs_pkg::RES_INSERTED;
                        wr_en     = 1'b1;
                    end
                end
                else if (32'(probes_reg) == SHARD_SLOTS - 1)
                begin
                    present_next = 1'b0;
                    code_next    = is_query_reg ? slphs_pkg::RES_ABSENT
                                                : slphs_pkg::RES_FULL;
                end
                else
                begin
                    slot_next   = slot_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    st_next     = S_READ;
                end
            end
            S_RESP:
                if (rsp.ready)
                    st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLEAR;
            limit_reg <= 7'd48;
            clr_reg   <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (st_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && req.valid)
        begin
            is_query_reg <= req.req_type;
            klo_reg      <= req.fp_low;
            khi_reg      <= req.fp_high;
            shard_reg    <= shard_in;
        end
        slot_reg    <= slot_next;
        probes_reg  <= probes_next;
        present_reg <= present_next;
        code_reg    <= code_next;
    end

    // Key memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_lo[addr] <= klo_reg;
            mem_hi[addr] <= khi_reg;
        end
        rd_lo <= mem_lo[addr];
        rd_hi <= mem_hi[addr];
    end

    // Valid-bit memory, swept clear after reset.
    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLEAR)
            mem_v[clr_reg] <= 1'b0;
        else if (wr_en)
            mem_v[addr] <= 1'b1;
        rd_v <= mem_v[addr];
    end

    // Fill counters: cleared in the first cycles of the sweep; shard_reg is
    // stable from hashing on, so the registered read is current at compare.
    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLEAR)
        begin
            if (32'(clr_reg) < SHARD_COUNT)
                fill_mem[clr_reg[SH_W-1:0]] <= '0;
        end
        else if (wr_en)
            fill_mem[shard_reg] <= fill_rd + 1'b1;
        fill_rd <= fill_mem[shard_reg];
    end
endmodule
